>>> rtl/ogi_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the obstacle inflation unit.
package ogi_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int POS_W      = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS,
        CFG_WIDTH,
        CFG_HEIGHT
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLS_OPEN,
        CLS_OBST,
        CLS_INFL,
        CLS_MARK
    } cell_class_t;

    typedef enum logic {
        CMD_CELL,
        CMD_DRAIN
    } command_t;

    typedef struct packed {
        logic [2:0]            radius;
        logic [CFG_DATA_W-1:0] frame_width;
        logic [CFG_DATA_W-1:0] frame_height;
    } cfg_regs_t;

endpackage

>>> rtl/ogi_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read, write-first on collision.
module ogi_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 1,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (we && waddr == raddr) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ogi_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: radius, frame width and frame height.
module ogi_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ogi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ogi_pkg::CFG_DATA_W-1:0] cfg_data,
    output ogi_pkg::cfg_regs_t             regs
);
    import ogi_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    always_comb begin
        regs_next = regs_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_RADIUS: regs_next.radius       = cfg_data[2:0];
                CFG_WIDTH:  regs_next.frame_width  = cfg_data;
                CFG_HEIGHT: regs_next.frame_height = cfg_data;
                default:    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.radius       <= 3'd1;
            regs_reg.frame_width  <= CFG_DATA_W'(1024);
            regs_reg.frame_height <= CFG_DATA_W'(1024);
        end else begin
            regs_reg <= regs_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

endmodule

>>> rtl/ogi_window.sv
`timescale 1ns / 1ps
// Horizontal window: row of column hits around the emitted cell, clipped at the row edges.
module ogi_window #(
    parameter int MAX_RADIUS = 7,
    parameter int CI         = 10,
    parameter int CB         = 11,
    parameter int RR         = 3
) (
    input  logic          aclk,
    input  logic          shift_en,
    input  logic          v_in,
    input  logic [RR-1:0] radius,
    input  logic [CI-1:0] ec,
    input  logic [CB-1:0] width,
    output logic          hit
);

    localparam int NW = 2 * MAX_RADIUS + 1;

    logic [NW-2:0] sr_reg;
    logic [NW-1:0] win;

    assign win = {sr_reg, v_in};

    // win[j] holds the column hit at offset radius - j from the emitted column
    always_comb begin
        int s;
        s   = int'(ec) + int'(radius);
        hit = 1'b0;
        for (int j = 0; j < NW; j++) begin
            if (win[j] && j <= 2 * int'(radius) && s >= j && s < int'(width) + j) begin
                hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sr_reg <= win[NW-2:0];
        end
    end

endmodule

>>> rtl/occupancy_grid_obstacle_inflation_unit.sv
`timescale 1ns / 1ps
// A transfer is held in the input register and its result in the result register; the
// cell R*W+R past a result's cell, or a drain, causes that result. Throughput: one item
// per cycle while the output is not stalled, set by the single-pass column-distance RAM
// update. After the last cell, drains wait while the column pass catches up.
// Reset: synchronous active low; clears control, sets config to defaults, RAMs are not cleared.
module occupancy_grid_obstacle_inflation_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ogi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ogi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [1:0]                     s_cell_class,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_out_class,
    output logic [ogi_pkg::POS_W-1:0]      m_out_row,
    output logic [ogi_pkg::POS_W-1:0]      m_out_col,
    output logic                           m_last
);
    import ogi_pkg::*;

    localparam int CI  = $clog2(MAX_WIDTH);
    localparam int CB  = $clog2(MAX_WIDTH + 1);
    localparam int RI  = $clog2(MAX_HEIGHT);
    localparam int RB  = $clog2(MAX_HEIGHT + 1);
    localparam int RR  = $clog2(MAX_RADIUS + 1);
    localparam int SAT = 2 * MAX_RADIUS + 1;
    localparam int DW  = $clog2(SAT + 1);
    localparam int DD  = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1;
    localparam int DA  = $clog2(DD);

    cfg_regs_t cfg;

    ogi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    logic [CB-1:0] clamp_w, fw_reg, fw_next, eff_w;
    logic [RB-1:0] clamp_h, fh_reg, fh_next, eff_h;
    logic [RR-1:0] clamp_r, fr_reg, fr_next, eff_r;

    always_comb begin
        if (cfg.frame_width == '0) begin
            clamp_w = CB'(1);
        end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
            clamp_w = CB'(MAX_WIDTH);
        end else begin
            clamp_w = CB'(cfg.frame_width);
        end
        if (cfg.frame_height == '0) begin
            clamp_h = RB'(1);
        end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
            clamp_h = RB'(MAX_HEIGHT);
        end else begin
            clamp_h = RB'(cfg.frame_height);
        end
        if (32'(cfg.radius) > MAX_RADIUS) begin
            clamp_r = RR'(MAX_RADIUS);
        end else begin
            clamp_r = RR'(cfg.radius);
        end
    end

    // Control and position state
    logic          started_reg, started_next;
    logic          done_reg, done_next;
    logic [RI-1:0] in_row_reg, in_row_next;
    logic [CI-1:0] in_col_reg, in_col_next;
    logic [RI-1:0] pr_reg, pr_next;
    logic [CI-1:0] pc_reg, pc_next;
    logic          pad_reg, pad_next;
    logic [RI-1:0] er_reg, er_next;
    logic [CI-1:0] ec_reg, ec_next;
    logic [RR-1:0] lead_reg, lead_next;
    logic [DA-1:0] wp_reg, wp_next;
    logic [DA-1:0] rp_reg, rp_next;

    // Input register
    logic             in_valid_reg, in_valid_next;
    logic             cmd_reg;
    logic [1:0]       cls_reg;

    // Result register
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       out_class_reg, out_class_next;
    logic [RI-1:0]    out_row_reg, out_row_next;
    logic [CI-1:0]    out_col_reg, out_col_next;
    logic             out_last_reg, out_last_next;

    // RAM and window hookup
    logic          col_we;
    logic [DW-1:0] d_new, col_rd;
    logic [CI-1:0] col_raddr;
    logic          dly_we;
    logic          obst_in, obst_rd;
    logic          prod, v_col, hit;

    logic out_free, proc, stream_item, drain_item, catch_up, emit, last_e;
    logic seed;

    assign eff_w = started_reg ? fw_reg : clamp_w;
    assign eff_h = started_reg ? fh_reg : clamp_h;
    assign eff_r = started_reg ? fr_reg : clamp_r;

    assign out_free    = !m_valid_reg || m_ready;
    assign stream_item = in_valid_reg && !done_reg && (command_t'(cmd_reg) == CMD_CELL);
    assign drain_item  = in_valid_reg && done_reg;
    assign proc        = in_valid_reg && out_free && (!done_reg || lead_reg == eff_r);
    assign catch_up    = done_reg && lead_reg != eff_r;
    assign s_ready     = !in_valid_reg || proc;

    assign seed    = cell_class_t'(cls_reg) != CLS_OPEN;
    assign obst_in = cell_class_t'(cls_reg) == CLS_OBST;

    // Rows since the last seed in this column, saturated; row 0 ignores the stale entry
    always_comb begin
        if (seed) begin
            d_new = '0;
        end else if (in_row_reg == '0 || col_rd == DW'(SAT)) begin
            d_new = DW'(SAT);
        end else begin
            d_new = col_rd + DW'(1);
        end
    end

    always_comb begin
        int thr;
        thr = int'(eff_h) - 1 - int'(pr_reg) + int'(eff_r);

        started_next   = started_reg;
        done_next      = done_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        pr_next        = pr_reg;
        pc_next        = pc_reg;
        pad_next       = pad_reg;
        er_next        = er_reg;
        ec_next        = ec_reg;
        lead_next      = lead_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        fr_next        = fr_reg;
        out_class_next = out_class_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        col_we         = 1'b0;
        dly_we         = 1'b0;
        prod           = 1'b0;
        emit           = 1'b0;
        v_col          = 1'b0;
        last_e         = 1'b0;

        if (proc && stream_item) begin
            if (!started_reg) begin
                started_next = 1'b1;
                fw_next      = clamp_w;
                fh_next      = clamp_h;
                fr_next      = clamp_r;
            end
            col_we  = 1'b1;
            dly_we  = 1'b1;
            wp_next = (32'(wp_reg) == DD - 1) ? '0 : wp_reg + DA'(1);
            if (CB'(in_col_reg) == eff_w - CB'(1)) begin
                in_col_next = '0;
                if (RB'(in_row_reg) == eff_h - RB'(1)) begin
                    done_next = 1'b1;
                end else begin
                    in_row_next = in_row_reg + RI'(1);
                end
            end else begin
                in_col_next = in_col_reg + CI'(1);
            end
            prod  = int'(in_row_reg) >= int'(eff_r);
            v_col = int'(d_new) <= 2 * int'(eff_r);
            if (eff_r == '0) begin
                emit = 1'b1;
            end else begin
                emit = prod && lead_reg == eff_r;
            end
        end else if (proc && drain_item) begin
            prod  = 1'b1;
            v_col = !pad_reg && int'(col_rd) <= thr;
            emit  = 1'b1;
        end else if (catch_up) begin
            prod  = 1'b1;
            v_col = !pad_reg && int'(col_rd) <= thr;
        end

        if (prod) begin
            if (lead_reg != eff_r) begin
                lead_next = lead_reg + RR'(1);
            end
            if (CB'(pc_reg) == eff_w - CB'(1)) begin
                pc_next = '0;
                if (RB'(pr_reg) == eff_h - RB'(1)) begin
                    pad_next = 1'b1;
                end else begin
                    pr_next = pr_reg + RI'(1);
                end
            end else begin
                pc_next = pc_reg + CI'(1);
            end
        end

        if (emit) begin
            last_e = RB'(er_reg) == eff_h - RB'(1) && CB'(ec_reg) == eff_w - CB'(1);
            m_valid_next  = 1'b1;
            out_row_next  = er_reg;
            out_col_next  = ec_reg;
            out_last_next = last_e;
            if (eff_r == '0) begin
                out_class_next = seed ? CLS_OBST : CLS_OPEN;
            end else if (obst_rd) begin
                out_class_next = CLS_OBST;
            end else if (hit) begin
                out_class_next = CLS_INFL;
            end else begin
                out_class_next = CLS_OPEN;
            end
            rp_next = (32'(rp_reg) == DD - 1) ? '0 : rp_reg + DA'(1);
            if (CB'(ec_reg) == eff_w - CB'(1)) begin
                ec_next = '0;
                er_next = er_reg + RI'(1);
            end else begin
                ec_next = ec_reg + CI'(1);
            end
        end

        // Frame end: return every counter to the start of a frame
        if (last_e) begin
            started_next = 1'b0;
            done_next    = 1'b0;
            in_row_next  = '0;
            in_col_next  = '0;
            pr_next      = '0;
            pc_next      = '0;
            pad_next     = 1'b0;
            er_next      = '0;
            ec_next      = '0;
            lead_next    = '0;
            wp_next      = '0;
            rp_next      = '0;
        end
    end

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    assign col_raddr = done_next ? pc_next : in_col_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            done_reg     <= 1'b0;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            pr_reg       <= '0;
            pc_reg       <= '0;
            pad_reg      <= 1'b0;
            er_reg       <= '0;
            ec_reg       <= '0;
            lead_reg     <= '0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            started_reg  <= started_next;
            done_reg     <= done_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            pr_reg       <= pr_next;
            pc_reg       <= pc_next;
            pad_reg      <= pad_next;
            er_reg       <= er_next;
            ec_reg       <= ec_next;
            lead_reg     <= lead_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fw_reg        <= fw_next;
        fh_reg        <= fh_next;
        fr_reg        <= fr_next;
        out_class_reg <= out_class_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
        if (s_valid && s_ready) begin
            cmd_reg <= s_command;
            cls_reg <= s_cell_class;
        end
    end

    ogi_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (DW),
        .AW    (CI)
    ) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (in_col_reg),
        .wdata (d_new),
        .raddr (col_raddr),
        .rdata (col_rd)
    );

    ogi_ram #(
        .DEPTH (DD),
        .WIDTH (1),
        .AW    (DA)
    ) u_obst_ram (
        .aclk  (aclk),
        .we    (dly_we),
        .waddr (wp_reg),
        .wdata (obst_in),
        .raddr (rp_next),
        .rdata (obst_rd)
    );

    ogi_window #(
        .MAX_RADIUS (MAX_RADIUS),
        .CI         (CI),
        .CB         (CB),
        .RR         (RR)
    ) u_window (
        .aclk     (aclk),
        .shift_en (prod),
        .v_in     (v_col),
        .radius   (eff_r),
        .ec       (ec_reg),
        .width    (eff_w),
        .hit      (hit)
    );

    assign m_valid     = m_valid_reg;
    assign m_out_class = out_class_reg;
    assign m_out_row   = POS_W'(out_row_reg);
    assign m_out_col   = POS_W'(out_col_reg);
    assign m_last      = out_last_reg;

endmodule

>>> rtl/ogi_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the obstacle inflation unit, bound to the top level.
module ogi_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [1:0]                m_out_class,
    input logic [ogi_pkg::POS_W-1:0] m_out_row,
    input logic [ogi_pkg::POS_W-1:0] m_out_col,
    input logic                      m_last
);
    import ogi_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_class) && $stable(m_out_row)
            && $stable(m_out_col) && $stable(m_last))
        else $error("stalled result changed");

    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_class != CLS_MARK)
        else $error("result class out of range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The result after a frame end starts the next frame at the origin
    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid || (m_out_row == '0 && m_out_col == '0))
        else $error("new frame does not start at origin");

endmodule

bind occupancy_grid_obstacle_inflation_unit ogi_checker u_ogi_checker (.*);

>>> test/ogi_checker.sv
`timescale 1ns / 1ps
// Checker of the obstacle inflation unit: tracks config, predicts and compares results.
module ogi_scoreboard (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ogi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ogi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_command,
    input  logic [1:0]                     s_cell_class,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [1:0]                     m_out_class,
    input  logic [ogi_pkg::POS_W-1:0]      m_out_row,
    input  logic [ogi_pkg::POS_W-1:0]      m_out_col,
    input  logic                           m_last,
    output int                             errors,
    output int                             pending
);
    import ogi_pkg::*;

    localparam int GRID_MAX = 1024;
    localparam int RAD_MAX  = 7;

    typedef struct packed {
        cell_class_t       cls;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } grid_result_t;

    grid_result_t inflated_q[$];

    bit seed_map [GRID_MAX*GRID_MAX];
    bit obst_map [GRID_MAX*GRID_MAX];

    int unsigned reg_r, reg_w, reg_h;
    int unsigned cur_w, cur_h, cur_r;
    int unsigned in_row, in_col, emit_idx;
    bit          in_done;

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v == 0) return 1;
        return (v > GRID_MAX) ? GRID_MAX : v;
    endfunction

    // Classify the next cell to leave the window and advance the emit counter.
    function automatic grid_result_t next_inflated();
        grid_result_t res;
        int unsigned er, ec, r0, r1, c0, c1;
        er = emit_idx / cur_w;
        ec = emit_idx % cur_w;
        if (cur_r == 0) begin
            res.cls = seed_map[emit_idx] ? CLS_OBST : CLS_OPEN;
        end else if (obst_map[emit_idx]) begin
            res.cls = CLS_OBST;
        end else begin
            r0 = (er >= cur_r) ? er - cur_r : 0;
            r1 = (er + cur_r < cur_h) ? er + cur_r : cur_h - 1;
            c0 = (ec >= cur_r) ? ec - cur_r : 0;
            c1 = (ec + cur_r < cur_w) ? ec + cur_r : cur_w - 1;
            res.cls = CLS_OPEN;
            for (int unsigned y = r0; y <= r1; y++)
                for (int unsigned x = c0; x <= c1; x++)
                    if (seed_map[y * cur_w + x]) res.cls = CLS_INFL;
        end
        res.row  = er[POS_W-1:0];
        res.col  = ec[POS_W-1:0];
        res.last = (emit_idx + 1 == cur_w * cur_h);
        emit_idx++;
        if (res.last) begin
            in_row   = 0;
            in_col   = 0;
            emit_idx = 0;
            in_done  = 0;
        end
        return res;
    endfunction

    // Append one expected result behind those already waiting.
    function automatic void queue_result(grid_result_t res);
        inflated_q = {inflated_q, res};
    endfunction

    assign pending = inflated_q.size();

    always @(posedge aclk) begin
        grid_result_t got, want;
        int unsigned idx;
        if (!aresetn) begin
            reg_r = 1; reg_w = 1024; reg_h = 1024;
            cur_r = 1; cur_w = 1024; cur_h = 1024;
            in_row = 0; in_col = 0; emit_idx = 0; in_done = 0;
            inflated_q.delete();
            errors <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_RADIUS: reg_r = cfg_data[2:0];
                    CFG_WIDTH:  reg_w = cfg_data;
                    CFG_HEIGHT: reg_h = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.cls  = cell_class_t'(m_out_class);
                got.row  = m_out_row;
                got.col  = m_out_col;
                got.last = m_last;
                if (inflated_q.size() == 0) begin
                    $display("%0t: unexpected result class %0d row %0d col %0d last %0d",
                             $time, got.cls, got.row, got.col, got.last);
                    errors <= errors + 1;
                end else begin
                    want = inflated_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected class %0d row %0d col %0d last %0d, got %0d %0d %0d %0d",
                                 $time, want.cls, want.row, want.col, want.last,
                                 got.cls, got.row, got.col, got.last);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (command_t'(s_command) == CMD_CELL && !in_done) begin
                    // latch geometry at the first cell of a frame
                    if (in_row == 0 && in_col == 0 && emit_idx == 0) begin
                        cur_w = clamp_dim(reg_w);
                        cur_h = clamp_dim(reg_h);
                        cur_r = (reg_r > RAD_MAX) ? RAD_MAX : reg_r;
                    end
                    idx = in_row * cur_w + in_col;
                    seed_map[idx] = (s_cell_class != CLS_OPEN);
                    obst_map[idx] = (s_cell_class == CLS_OBST);
                    in_col++;
                    if (in_col >= cur_w) begin
                        in_col = 0;
                        in_row++;
                        if (in_row >= cur_h) in_done = 1;
                    end
                    if (idx >= cur_r * cur_w + cur_r) queue_result(next_inflated());
                end else if (in_done) begin
                    queue_result(next_inflated());
                end
            end
        end
    end

endmodule

>>> test/occupancy_grid_obstacle_inflation_unit_test.sv
`timescale 1ns / 1ps
// Testbench top of the obstacle inflation unit: stimulus, watchdog and verdict.
module occupancy_grid_obstacle_inflation_unit_test;
    import ogi_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_command;
    logic [1:0]            s_cell_class;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_out_class;
    logic [POS_W-1:0]      m_out_row;
    logic [POS_W-1:0]      m_out_col;
    logic                  m_last;

    int errors;
    int pending;
    int idle_pct;
    int items_sent;
    int stall_cycles = 0;

    occupancy_grid_obstacle_inflation_unit u_top (.*);

    ogi_scoreboard u_checker (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Abort when no channel has moved a transfer for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready = ($urandom_range(0, 99) >= idle_pct);

    task automatic write_reg(cfg_index_t ridx, int unsigned value);
        cfg_valid = 1;
        cfg_index = ridx;
        cfg_data  = value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic send_item(command_t cmd, cell_class_t cls);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_valid      = 1;
        s_command    = cmd;
        s_cell_class = cls;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    function automatic cell_class_t random_class();
        if ($urandom_range(0, 99) < 70) return CLS_OPEN;
        return cell_class_t'($urandom_range(1, 3));
    endfunction

    // Hold until the block is idle, then program one frame and stream it out.
    task automatic run_frame(int unsigned r, int unsigned w, int unsigned h, bit directed);
        int unsigned ew, eh, er, total, lag, drains;
        s_valid = 0;
        wait (pending == 0);
        repeat (16) @(negedge aclk);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        ew = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
        eh = (h == 0) ? 1 : (h > 1024 ? 1024 : h);
        er = r & 7;
        total = ew * eh;
        lag   = er * ew + er;
        drains = (total < lag) ? total : lag;
        for (int unsigned i = 0; i < total; i++) begin
            // drains before the last cell give nothing
            if (i > 0 && $urandom_range(0, 99) < 5)
                send_item(CMD_DRAIN, cell_class_t'($urandom_range(0, 3)));
            send_item(CMD_CELL, directed ? cell_class_t'(i % 4) : random_class());
        end
        for (int unsigned i = 0; i < drains; i++)
            send_item(command_t'($urandom_range(0, 1)), cell_class_t'($urandom_range(0, 3)));
    endtask

    initial begin
        aresetn      = 0;
        cfg_valid    = 0;
        cfg_index    = CFG_RADIUS;
        cfg_data     = 0;
        s_valid      = 0;
        s_command    = CMD_CELL;
        s_cell_class = CLS_OPEN;
        idle_pct     = 32;
        items_sent   = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // drain with nothing in flight
        send_item(CMD_DRAIN, CLS_MARK);
        run_frame(1, 4, 3, 1);
        run_frame(0, 3, 2, 1);
        run_frame(7, 5, 4, 1);
        run_frame(2, 0, 6, 1);
        run_frame(3, 6, 0, 1);
        run_frame(7, 16, 1, 0);
        run_frame(0, 1, 40, 0);

        for (int k = 0; items_sent < 400; k++) begin
            idle_pct = (k >= 1 && k < 3) ? 0 : 32;
            run_frame($urandom_range(0, 7), $urandom_range(1, 16), $urandom_range(1, 10), 0);
        end

        s_valid = 0;
        wait (pending == 0);
        repeat (30) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/ogi_pkg.sv
rtl/ogi_ram.sv
rtl/ogi_cfg.sv
rtl/ogi_window.sv
rtl/occupancy_grid_obstacle_inflation_unit.sv
rtl/ogi_checker.sv
test/ogi_checker.sv
test/occupancy_grid_obstacle_inflation_unit_test.sv
